// ----- rtl/core/u8u16_pkg.sv -----
`default_nettype none

package u8u16_pkg;

    localparam int MaxResults = 4;
    localparam int PendDepth = 3;

    localparam logic [20:0] REPLACEMENT = 21'h00fffd;
    localparam logic [20:0] MAX_CODE_POINT = 21'h10ffff;
    localparam logic [20:0] SURR_FIRST = 21'h00d800;
    localparam logic [20:0] SURR_LAST = 21'h00dfff;
    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [20:0] BMP_LAST = 21'h00ffff;
    localparam logic [15:0] HI_SURR_BASE = 16'hd800;
    localparam logic [15:0] LO_SURR_BASE = 16'hdc00;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in_word;

    typedef struct packed {
        logic [20:0] code_unit;
        logic        last_of_run;
        logic        string_end;
    } t_result;

    typedef struct packed {
        t_result [MaxResults-1:0] res;
        logic [2:0]               count;
    } t_result_set;

endpackage

`default_nettype wire

// ----- rtl/core/u8u16_in_reg.sv -----
`default_nettype none

module u8u16_in_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire u8u16_pkg::t_in_word i_word,
    input  wire logic               i_take,
    output logic                    o_valid,
    output u8u16_pkg::t_in_word     o_word
);
    import u8u16_pkg::*;

    logic     r_valid;
    t_in_word r_word;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_word <= i_word;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/u8u16_decode.sv -----
`default_nettype none

module u8u16_decode (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_take,
    input  wire logic                i_wide,
    input  wire u8u16_pkg::t_in_word i_word,
    output u8u16_pkg::t_result_set   o_set
);
    import u8u16_pkg::*;

    logic [7:0]  r_pend [PendDepth];
    logic [1:0]  r_pend_cnt;
    logic [7:0]  n_pend [PendDepth];
    logic [1:0]  n_pend_cnt;

    logic [7:0]  w [4];
    logic [2:0]  n;
    logic [2:0]  pos;
    logic [2:0]  k;
    logic [2:0]  idx;
    logic        done;
    logic        fin;
    logic [7:0]  b;
    logic [7:0]  nb;
    logic [1:0]  cc;
    logic        bad;
    logic [1:0]  bad_at;
    logic [20:0] cp;
    logic [19:0] adj;
    logic [20:0] unit_hi;
    logic [20:0] unit_lo;
    t_result_set n_set;

    always_comb begin
        fin = i_word.end_of_string;
        n   = {1'b0, r_pend_cnt} + 3'd1;
        for (int j = 0; j < PendDepth; j++) begin
            w[j] = (r_pend_cnt == 2'(j)) ? i_word.in_byte : r_pend[j];
        end
        w[3] = i_word.in_byte;

        n_set   = '0;
        pos     = '0;
        k       = '0;
        done    = 1'b0;
        b       = '0;
        nb      = '0;
        cc      = '0;
        bad     = 1'b0;
        bad_at  = '0;
        cp      = '0;
        adj     = '0;
        unit_hi = '0;
        unit_lo = '0;
        idx     = '0;

        for (int s = 0; s < 4; s++) begin
            if (!done && pos < n) begin
                b = w[pos[1:0]];
                if (!b[7]) begin
                    if (k < 3'd4) begin
                        n_set.res[k[1:0]].code_unit = {13'd0, b};
                        k = k + 3'd1;
                    end
                    pos = pos + 3'd1;
                end else begin
                    if (b[7:5] == 3'b110) begin
                        cc = 2'd1;
                    end else if (b[7:4] == 4'b1110) begin
                        cc = 2'd2;
                    end else if (b[7:3] == 5'b11110) begin
                        cc = 2'd3;
                    end else begin
                        cc = 2'd0;
                    end

                    if (cc == 2'd0) begin
                        if (k < 3'd4) begin
                            n_set.res[k[1:0]].code_unit = REPLACEMENT;
                            k = k + 3'd1;
                        end
                        pos = pos + 3'd1;
                    end else if (pos + 3'd1 + {1'b0, cc} > n) begin
                        if (fin) begin
                            if (k < 3'd4) begin
                                n_set.res[k[1:0]].code_unit = REPLACEMENT;
                                k = k + 3'd1;
                            end
                            pos = n;
                        end
                        done = 1'b1;
                    end else begin
                        bad    = 1'b0;
                        bad_at = '0;
                        for (int i = 2; i >= 0; i--) begin
                            if (2'(i) < cc) begin
                                idx = pos + 3'd1 + 3'(i);
                                nb  = w[idx[1:0]];
                                if (nb[7:6] != 2'b10) begin
                                    bad    = 1'b1;
                                    bad_at = 2'(i);
                                end
                            end
                        end

                        if (bad) begin
                            if (k < 3'd4) begin
                                n_set.res[k[1:0]].code_unit = REPLACEMENT;
                                k = k + 3'd1;
                            end
                            pos = pos + 3'd1 + {1'b0, bad_at};
                        end else begin
                            case (cc)
                                2'd1:    cp = {10'd0, b[4:0], w[pos[1:0] + 2'd1][5:0]};
                                2'd2:    cp = {5'd0, b[3:0], w[pos[1:0] + 2'd1][5:0],
                                               w[pos[1:0] + 2'd2][5:0]};
                                default: cp = {b[2:0], w[pos[1:0] + 2'd1][5:0],
                                               w[pos[1:0] + 2'd2][5:0],
                                               w[pos[1:0] + 2'd3][5:0]};
                            endcase
                            pos = pos + 3'd1 + {1'b0, cc};

                            if (cp > MAX_CODE_POINT || (cp >= SURR_FIRST && cp <= SURR_LAST)) begin
                                cp = REPLACEMENT;
                            end

                            if (cp > BMP_LAST && !i_wide) begin
                                adj     = 20'(cp - SUPP_BASE);
                                unit_hi = {5'd0, HI_SURR_BASE + {6'd0, adj[19:10]}};
                                unit_lo = {5'd0, LO_SURR_BASE + {6'd0, adj[9:0]}};
                                if (k < 3'd4) begin
                                    n_set.res[k[1:0]].code_unit = unit_hi;
                                    k = k + 3'd1;
                                end
                                if (k < 3'd4) begin
                                    n_set.res[k[1:0]].code_unit = unit_lo;
                                    k = k + 3'd1;
                                end
                            end else begin
                                if (k < 3'd4) begin
                                    n_set.res[k[1:0]].code_unit = cp;
                                    k = k + 3'd1;
                                end
                            end
                        end
                    end
                end
            end
        end

        if (k != 3'd0) begin
            idx = k - 3'd1;
            n_set.res[idx[1:0]].last_of_run = 1'b1;
            n_set.res[idx[1:0]].string_end  = fin;
        end
        n_set.count = k;

        n_pend_cnt = 2'(n - pos);
        for (int j = 0; j < PendDepth; j++) begin
            idx       = pos + 3'(j);
            n_pend[j] = w[idx[1:0]];
        end
    end

    assign o_set = n_set;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= '0;
        end else if (i_take) begin
            r_pend_cnt <= n_pend_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            for (int j = 0; j < PendDepth; j++) begin
                r_pend[j] <= n_pend[j];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/u8u16_out_buf.sv -----
`default_nettype none

module u8u16_out_buf (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire u8u16_pkg::t_result_set i_set,
    output logic                       o_can_load,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output u8u16_pkg::t_result         o_result
);
    import u8u16_pkg::*;

    t_result    r_res [MaxResults];
    logic [2:0] r_cnt;
    logic       pop;

    assign pop        = (r_cnt != 3'd0) && i_ready;
    assign o_can_load = (r_cnt == 3'd0) || (r_cnt == 3'd1 && i_ready);
    assign o_valid    = (r_cnt != 3'd0);
    assign o_result   = r_res[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_set.count;
        end else if (pop) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int j = 0; j < MaxResults; j++) begin
                r_res[j] <= i_set.res[j];
            end
        end else if (pop) begin
            for (int j = 0; j < MaxResults - 1; j++) begin
                r_res[j] <= r_res[j+1];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/utf8_to_utf16_decoder_core.sv -----
// path: input register, combinational decode, result buffer register
// throughput: one input word per cycle unless stalled; a word that yields
//   several results holds decode until its last goes out (4-entry buffer)
// reset: synchronous active low; clears pending byte count, buffer count,
//   input valid flag and the wide mode flag, no clearing pass
`default_nettype none

module utf8_to_utf16_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_end_of_string,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [20:0]      o_code_unit,
    output logic             o_last_of_run,
    output logic             o_string_end
);
    import u8u16_pkg::*;

    logic        r_wide;
    t_in_word    in_word;
    t_in_word    dec_word;
    logic        dec_valid;
    logic        can_load;
    logic        take;
    t_result_set dec_set;
    t_result     out_res;

    assign in_word.in_byte       = i_in_byte;
    assign in_word.end_of_string = i_end_of_string;
    assign take                  = dec_valid && can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide <= 1'b0;
        end else if (i_cfg_we) begin
            r_wide <= i_cfg_wdata;
        end
    end

    u8u16_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_word  (in_word),
        .i_take  (take),
        .o_valid (dec_valid),
        .o_word  (dec_word)
    );

    u8u16_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_wide  (r_wide),
        .i_word  (dec_word),
        .o_set   (dec_set)
    );

    u8u16_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_set      (dec_set),
        .o_can_load (can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_res)
    );

    assign o_code_unit   = out_res.code_unit;
    assign o_last_of_run = out_res.last_of_run;
    assign o_string_end  = out_res.string_end;

endmodule

`default_nettype wire
